/* rtl/nprs_pkg.sv */
// Shared constants, codes and job descriptor for the NAND page read sequencer.
package nprs_pkg;

  localparam int PAGE_BYTES  = 2048;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_READY = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic [2:0] ACT_SELECT   = 3'd0;
  localparam logic [2:0] ACT_CMD      = 3'd1;
  localparam logic [2:0] ACT_ADDR     = 3'd2;
  localparam logic [2:0] ACT_DATA     = 3'd3;
  localparam logic [2:0] ACT_DESELECT = 3'd4;
  localparam logic [2:0] ACT_IGNORED  = 3'd5;

  localparam logic [7:0] CMD_READ         = 8'h00;
  localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;

  typedef enum logic [1:0] {
    HEAD_SELECT,
    HEAD_DATA,
    HEAD_IGNORED
  } head_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DESELECT,
    TAIL_READ
  } tail_t;

  typedef struct packed {
    head_t       head;
    tail_t       tail;
    logic [7:0]  data;
    logic [23:0] index;
    logic [31:0] address;
  } job_t;

endpackage

/* rtl/nprs_front.sv */
// Front end: accepts input transactions, tracks read state, emits job descriptors.
module nprs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    opcode,
  input  logic [31:0]   start_address,
  input  logic [23:0]   length,
  input  logic [7:0]    data_byte,
  output logic          job_valid,
  output nprs_pkg::job_t job,
  input  logic          job_full
);
  import nprs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_DATA
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] current_address, current_address_next;
  logic [23:0] bytes_left, bytes_left_next;
  logic [23:0] write_index, write_index_next;
  logic        accept;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next           = phase;
    current_address_next = current_address;
    bytes_left_next      = bytes_left;
    write_index_next     = write_index;
    job_valid            = 1'b0;
    job.head             = HEAD_IGNORED;
    job.tail             = TAIL_NONE;
    job.data             = 8'h00;
    job.index            = 24'd0;
    job.address          = current_address;
    if (accept) begin
      if (opcode == OP_START && phase == PH_IDLE) begin
        current_address_next = start_address;
        bytes_left_next      = length;
        write_index_next     = 24'd0;
        job_valid            = 1'b1;
        job.head             = HEAD_SELECT;
        job.address          = start_address;
        if (length == 24'd0) begin
          job.tail = TAIL_DESELECT;
        end else begin
          job.tail   = TAIL_READ;
          phase_next = PH_WAIT;
        end
      end else if (opcode == OP_READY && phase == PH_WAIT) begin
        phase_next = PH_DATA;
      end else if (opcode == OP_DATA && phase == PH_DATA) begin
        current_address_next = current_address + 32'd1;
        bytes_left_next      = bytes_left - 24'd1;
        write_index_next     = write_index + 24'd1;
        job_valid            = 1'b1;
        job.head             = HEAD_DATA;
        job.data             = data_byte;
        job.index            = write_index;
        job.address          = current_address_next;
        if (bytes_left_next == 24'd0) begin
          job.tail   = TAIL_DESELECT;
          phase_next = PH_IDLE;
        end else if (current_address_next[PAGE_SHIFT-1:0] == '0) begin
          job.tail   = TAIL_READ;
          phase_next = PH_WAIT;
        end
      end else begin
        job_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      current_address <= 32'd0;
      bytes_left      <= 24'd0;
      write_index     <= 24'd0;
    end else begin
      phase           <= phase_next;
      current_address <= current_address_next;
      bytes_left      <= bytes_left_next;
      write_index     <= write_index_next;
    end
  end

endmodule

/* rtl/nprs_queue.sv */
// Short job queue between the front and back ends.
module nprs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nprs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output nprs_pkg::job_t head_job
);
  import nprs_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic              do_pop;

  assign full       = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if ((push && !full) && !do_pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (!(push && !full) && do_pop) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

/* rtl/nprs_back.sv */
// Back end: expands each job into result transactions through an output register.
module nprs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  nprs_pkg::job_t job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     action,
  output logic [7:0]     value,
  output logic [23:0]    buffer_index,
  output logic           last
);
  import nprs_pkg::*;

  logic [2:0]  step;
  logic        load;
  logic        final_step;
  logic [15:0] col;
  logic [23:0] page;
  logic [2:0]  act_c;
  logic [7:0]  val_c;
  logic [23:0] idx_c;

  assign load = job_valid && (!out_valid || out_ready);
  assign col  = 16'(job.address & 32'(PAGE_BYTES - 1));
  assign page = 24'(job.address >> PAGE_SHIFT);

  always_comb begin
    final_step = 1'b0;
    case (job.tail)
      TAIL_NONE:     final_step = (step == 3'd0);
      TAIL_DESELECT: final_step = (step == 3'd1);
      default:       final_step = (step == 3'd7);
    endcase
  end

  assign job_pop = load && final_step;

  always_comb begin
    act_c = ACT_IGNORED;
    val_c = 8'h00;
    idx_c = 24'd0;
    if (step == 3'd0) begin
      unique case (job.head)
        HEAD_SELECT: act_c = ACT_SELECT;
        HEAD_DATA: begin
          act_c = ACT_DATA;
          val_c = job.data;
          idx_c = job.index;
        end
        default: act_c = ACT_IGNORED;
      endcase
    end else if (job.tail == TAIL_DESELECT) begin
      act_c = ACT_DESELECT;
    end else begin
      unique case (step)
        3'd1: begin
          act_c = ACT_CMD;
          val_c = CMD_READ;
        end
        3'd2: begin
          act_c = ACT_ADDR;
          val_c = col[7:0];
        end
        3'd3: begin
          act_c = ACT_ADDR;
          val_c = col[15:8];
        end
        3'd4: begin
          act_c = ACT_ADDR;
          val_c = page[7:0];
        end
        3'd5: begin
          act_c = ACT_ADDR;
          val_c = page[15:8];
        end
        3'd6: begin
          act_c = ACT_ADDR;
          val_c = page[23:16];
        end
        default: begin
          act_c = ACT_CMD;
          val_c = CMD_READ_CONFIRM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= final_step ? 3'd0 : step + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action       <= act_c;
      value        <= val_c;
      buffer_index <= idx_c;
      last         <= final_step;
    end
  end

endmodule

/* rtl/nand_page_read_sequencer_core.sv */
// Top level of the large-page NAND read sequencer.
// The first result is registered in a job queue slot and then in the output register.
// One input per cycle unless the queue is full; one result per cycle unless stalled.
// A start or page crossing expands into up to 8 results, one per cycle unless stalled.
// Synchronous active-high reset clears phase, address, count, index, queue, out_valid.
module nand_page_read_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] start_address,
  input  logic [23:0] length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [7:0]  value,
  output logic [23:0] buffer_index,
  output logic        last
);
  import nprs_pkg::*;

  logic job_push;
  job_t push_job;
  logic queue_full;
  logic job_pop;
  logic head_valid;
  job_t head_job;

  nprs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .start_address (start_address),
    .length        (length),
    .data_byte     (data_byte),
    .job_valid     (job_push),
    .job           (push_job),
    .job_full      (queue_full)
  );

  nprs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  nprs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (head_valid),
    .job          (head_job),
    .job_pop      (job_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .value        (value),
    .buffer_index (buffer_index),
    .last         (last)
  );

endmodule

/* rtl/nprs_checker.sv */
// Port-level checker for the NAND page read sequencer, with its bind.
module nprs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  action,
  input logic [7:0]  value,
  input logic [23:0] buffer_index,
  input logic        last
);
  import nprs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(value)
      && $stable(buffer_index) && $stable(last))
    else $error("result changed while stalled");

  a_ends_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_IGNORED || action == ACT_DESELECT) |-> last)
    else $error("ignored or deselect not final");

  a_select_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_SELECT || action == ACT_ADDR) |-> !last)
    else $error("select or address marked final");

  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_CMD |-> value == CMD_READ || value == CMD_READ_CONFIRM)
    else $error("bad command byte");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != ACT_DATA |-> buffer_index == 24'd0)
    else $error("nonzero index on non-data result");

endmodule

bind nand_page_read_sequencer_core nprs_checker u_nprs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .action       (action),
  .value        (value),
  .buffer_index (buffer_index),
  .last         (last)
);
